>>> rtl/crt_pkg.sv
`timescale 1ns / 1ps
// Package for the core reservation table: cell and mode codes, field widths,
// reset values and the memory request struct. No dependencies.
package crt_pkg;

	localparam int NUM_CORES_DEF = 64;

	localparam int MODE_W  = 2;
	localparam int COUNT_W = 7;
	localparam int INDEX_W = 6;
	localparam int MASK_W  = 64;

	localparam logic [COUNT_W-1:0] ACTIVE_CORES_RST = 7'd48;

	typedef enum logic [1:0] {
		CELL_VACANT = 2'd0,
		CELL_OPP    = 2'd1,
		CELL_OWNER  = 2'd2
	} cell_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLAIM_MANY = 2'd0,
		MODE_OWNER_CLAIM = 2'd1,
		MODE_OPP_RELEASE = 2'd2,
		MODE_OWNER_RELEASE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_ROLL,
		ST_ONE_RD,
		ST_ONE_CHK,
		ST_DONE
	} state_t;

	// Read and write request into the cell memory
	typedef struct packed {
		logic               rd_en;
		logic [INDEX_W-1:0] rd_addr;
		logic               wr_en;
		logic [INDEX_W-1:0] wr_addr;
		cell_t              wr_data;
	} mem_req_t;

endpackage

>>> rtl/crt_ifc.sv
`timescale 1ns / 1ps
// Channel interfaces of the core reservation table: request, response and
// configuration write. Depends on crt_pkg for field widths.
interface crt_req_if;
	logic                          valid;
	logic                          ready;
	logic [crt_pkg::MODE_W-1:0]    mode;
	logic [crt_pkg::COUNT_W-1:0]   request_count;
	logic [crt_pkg::INDEX_W-1:0]   core_index;

	modport source (output valid, mode, request_count, core_index, input ready);
	modport sink (input valid, mode, request_count, core_index, output ready);
endinterface

interface crt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [crt_pkg::MASK_W-1:0]    granted_mask;
	logic [crt_pkg::COUNT_W-1:0]   found_count;
	logic                          success;
	logic [1:0]                    prior_state;
	logic                          index_error;

	modport source (output valid, granted_mask, found_count, success, prior_state,
		index_error, input ready);
	modport sink (input valid, granted_mask, found_count, success, prior_state,
		index_error, output ready);
endinterface

interface crt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [crt_pkg::COUNT_W-1:0]   active_cores;

	modport source (output valid, active_cores, input ready);
	modport sink (input valid, active_cores, output ready);
endinterface

>>> rtl/core_reservation_table.sv
`timescale 1ns / 1ps
// Top level of the core reservation table: configuration register, cell
// memory and request sequencer. Uses crt_pkg, crt_ifc, crt_cell_mem, crt_ctrl.
//
//  channel | dir | payload                                              | accept
//  req     | in  | mode, request_count, core_index                      | valid & ready
//  rsp     | out | granted_mask, found_count, success, prior_state,     | valid & ready
//          |     | index_error                                          |
//  cfg     | in  | active_cores                                         | valid & ready
//
// Claim-many reads each cell it visits, then checks and writes it; a failed
// claim adds a rollback pass that frees the cells it took. Single-cell requests
// read, then check and write one cell; an out-of-range index skips the memory.
// Reset clears all cells at once through per-entry valid flops; no sweep.
// One request is in work at a time; the response register lets the next
// request be taken while the previous response waits for rsp.ready.
module core_reservation_table #(
	parameter int NUM_CORES = crt_pkg::NUM_CORES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	crt_req_if.sink     req,
	crt_rsp_if.source   rsp,
	crt_cfg_if.sink     cfg
);

	localparam logic [crt_pkg::COUNT_W-1:0] NUM_CORES_C = crt_pkg::COUNT_W'(NUM_CORES);

	logic [crt_pkg::COUNT_W-1:0] active_cores_q;
	logic [crt_pkg::COUNT_W-1:0] limit;
	crt_pkg::mem_req_t           mem_req;
	crt_pkg::cell_t              rd_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cores_q <= crt_pkg::ACTIVE_CORES_RST;
		end else if (cfg.valid && cfg.ready) begin
			active_cores_q <= cfg.active_cores;
		end
	end

	// scan limit saturates at the table size
	assign limit = (active_cores_q > NUM_CORES_C) ? NUM_CORES_C : active_cores_q;

	crt_cell_mem #(
		.NUM_CORES (NUM_CORES)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	crt_ctrl #(
		.NUM_CORES (NUM_CORES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.limit   (limit),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

endmodule

>>> rtl/crt_cell_mem.sv
`timescale 1ns / 1ps
// Cell state memory: one write and one read port, registered read data.
// Per-entry valid flops make every cell read as free after reset. Uses crt_pkg.
module crt_cell_mem #(
	parameter int NUM_CORES = crt_pkg::NUM_CORES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  crt_pkg::mem_req_t mem_req,
	output crt_pkg::cell_t    rd_data
);

	localparam int IDX_W = $clog2(NUM_CORES);

	logic [1:0]           mem_q [NUM_CORES];
	logic [NUM_CORES-1:0] vld_q;
	logic [1:0]           rd_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[mem_req.wr_addr[IDX_W-1:0]] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_q <= mem_q[mem_req.rd_addr[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_req.wr_en) begin
				vld_q[mem_req.wr_addr[IDX_W-1:0]] <= 1'b1;
			end
			if (mem_req.rd_en) begin
				rd_vld_q <= vld_q[mem_req.rd_addr[IDX_W-1:0]];
			end
		end
	end

	// never-written cells are free
	assign rd_data = rd_vld_q ? crt_pkg::cell_t'(rd_q) : crt_pkg::CELL_VACANT;

	// the sequencer never reads a cell in the cycle it writes it
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en && mem_req.wr_en |-> mem_req.rd_addr != mem_req.wr_addr)
		else $error("read and write to the same cell in one cycle");

endmodule

>>> rtl/crt_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: claim-many scan with rollback, single-cell claim and
// release, and the response register. Uses crt_pkg and the channel interfaces.
module crt_ctrl #(
	parameter int NUM_CORES = crt_pkg::NUM_CORES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	crt_req_if.sink                        req,
	crt_rsp_if.source                      rsp,
	input  logic [crt_pkg::COUNT_W-1:0]    limit,
	output crt_pkg::mem_req_t              mem_req,
	input  crt_pkg::cell_t                 rd_data
);

	localparam int IDX_W = $clog2(NUM_CORES);
	localparam int CNT_W = $clog2(NUM_CORES + 1);

	crt_pkg::state_t               state_q, state_d;
	logic [crt_pkg::MODE_W-1:0]    mode_q;
	logic [crt_pkg::COUNT_W-1:0]   need_q;
	logic [crt_pkg::INDEX_W-1:0]   idx_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [crt_pkg::COUNT_W-1:0]   found_q;
	logic [NUM_CORES-1:0]          mask_q;
	crt_pkg::cell_t                prior_q;
	logic                          ierr_q;
	logic                          succ_q;

	logic                          rsp_vld_q;
	logic [crt_pkg::MASK_W-1:0]    rsp_mask_q;
	logic [crt_pkg::COUNT_W-1:0]   rsp_found_q;
	logic                          rsp_succ_q;
	logic [1:0]                    rsp_prior_q;
	logic                          rsp_ierr_q;

	logic                          req_acc;
	logic                          idx_err;
	logic                          cnt_in;
	logic                          short;
	logic                          scan_more;
	logic                          load_rsp;
	logic [IDX_W-1:0]              cnt_idx;

	assign cnt_idx   = cnt_q[IDX_W-1:0];
	assign cnt_in    = crt_pkg::COUNT_W'(cnt_q) < limit;
	assign short     = found_q < need_q;
	assign scan_more = cnt_in && short;
	assign idx_err   = {1'b0, req.core_index} >= limit;
	assign req_acc   = req.valid && req.ready;
	assign load_rsp  = (state_q == crt_pkg::ST_DONE) && (!rsp_vld_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			crt_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (req.mode == crt_pkg::MODE_CLAIM_MANY) begin
						state_d = crt_pkg::ST_SCAN;
					end else if (idx_err) begin
						state_d = crt_pkg::ST_DONE;
					end else begin
						state_d = crt_pkg::ST_ONE_RD;
					end
				end
			end
			crt_pkg::ST_SCAN: begin
				if (scan_more) begin
					state_d = crt_pkg::ST_SCAN_CHK;
				end else if (short) begin
					state_d = crt_pkg::ST_ROLL;
				end else begin
					state_d = crt_pkg::ST_DONE;
				end
			end
			crt_pkg::ST_SCAN_CHK: state_d = crt_pkg::ST_SCAN;
			crt_pkg::ST_ROLL: begin
				if (!cnt_in) begin
					state_d = crt_pkg::ST_DONE;
				end
			end
			crt_pkg::ST_ONE_RD:  state_d = crt_pkg::ST_ONE_CHK;
			crt_pkg::ST_ONE_CHK: state_d = crt_pkg::ST_DONE;
			crt_pkg::ST_DONE: begin
				if (load_rsp) begin
					state_d = crt_pkg::ST_IDLE;
				end
			end
			default: state_d = crt_pkg::ST_IDLE;
		endcase
	end

	// memory requests
	always_comb begin
		mem_req = '{rd_en: 1'b0, rd_addr: '0, wr_en: 1'b0, wr_addr: '0,
			wr_data: crt_pkg::CELL_VACANT};
		case (state_q)
			crt_pkg::ST_SCAN: begin
				mem_req.rd_en   = scan_more;
				mem_req.rd_addr = crt_pkg::INDEX_W'(cnt_q);
			end
			crt_pkg::ST_SCAN_CHK: begin
				mem_req.wr_en   = (rd_data == crt_pkg::CELL_VACANT);
				mem_req.wr_addr = crt_pkg::INDEX_W'(cnt_q);
				mem_req.wr_data = crt_pkg::CELL_OPP;
			end
			crt_pkg::ST_ROLL: begin
				mem_req.wr_en   = cnt_in && mask_q[cnt_idx];
				mem_req.wr_addr = crt_pkg::INDEX_W'(cnt_q);
				mem_req.wr_data = crt_pkg::CELL_VACANT;
			end
			crt_pkg::ST_ONE_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = idx_q;
			end
			crt_pkg::ST_ONE_CHK: begin
				mem_req.wr_addr = idx_q;
				case (mode_q)
					crt_pkg::MODE_OWNER_CLAIM: begin
						mem_req.wr_en   = (rd_data == crt_pkg::CELL_VACANT);
						mem_req.wr_data = crt_pkg::CELL_OWNER;
					end
					crt_pkg::MODE_OPP_RELEASE: begin
						mem_req.wr_en = (rd_data == crt_pkg::CELL_OPP);
					end
					crt_pkg::MODE_OWNER_RELEASE: begin
						mem_req.wr_en = (rd_data == crt_pkg::CELL_OWNER);
					end
					default: mem_req.wr_en = 1'b0;
				endcase
			end
			default: mem_req.wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= crt_pkg::ST_IDLE;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			crt_pkg::ST_IDLE: begin
				if (req_acc) begin
					mode_q  <= req.mode;
					need_q  <= req.request_count;
					idx_q   <= req.core_index;
					cnt_q   <= '0;
					found_q <= '0;
					mask_q  <= '0;
					prior_q <= crt_pkg::CELL_VACANT;
					ierr_q  <= (req.mode != crt_pkg::MODE_CLAIM_MANY) && idx_err;
					succ_q  <= 1'b0;
				end
			end
			crt_pkg::ST_SCAN: begin
				if (!scan_more) begin
					if (short) begin
						cnt_q <= '0;
					end else begin
						succ_q <= 1'b1;
					end
				end
			end
			crt_pkg::ST_SCAN_CHK: begin
				if (rd_data == crt_pkg::CELL_VACANT) begin
					mask_q[cnt_idx] <= 1'b1;
					found_q         <= found_q + 7'd1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
			crt_pkg::ST_ROLL: begin
				if (cnt_in) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					mask_q <= '0;
				end
			end
			crt_pkg::ST_ONE_CHK: begin
				prior_q <= rd_data;
				succ_q  <= (mode_q == crt_pkg::MODE_OWNER_CLAIM) &&
					(rd_data != crt_pkg::CELL_OPP);
			end
			default: begin
			end
		endcase

		if (load_rsp) begin
			rsp_mask_q  <= crt_pkg::MASK_W'(mask_q);
			rsp_found_q <= found_q;
			rsp_succ_q  <= succ_q;
			rsp_prior_q <= prior_q;
			rsp_ierr_q  <= ierr_q;
		end
	end

	assign req.ready        = (state_q == crt_pkg::ST_IDLE);
	assign rsp.valid        = rsp_vld_q;
	assign rsp.granted_mask = rsp_mask_q;
	assign rsp.found_count  = rsp_found_q;
	assign rsp.success      = rsp_succ_q;
	assign rsp.prior_state  = rsp_prior_q;
	assign rsp.index_error  = rsp_ierr_q;

	a_scan_mask_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crt_pkg::ST_SCAN || state_q == crt_pkg::ST_SCAN_CHK)
		|-> $countones(mask_q) == 32'(found_q))
		else $error("claimed mask disagrees with found count");

	a_scan_no_overshoot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crt_pkg::ST_SCAN || state_q == crt_pkg::ST_SCAN_CHK)
		|-> found_q <= need_q)
		else $error("scan claimed more cells than requested");

	a_roll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == crt_pkg::ST_ROLL && state_d == crt_pkg::ST_DONE
		|=> mask_q == '0 && !succ_q)
		else $error("rollback left claimed cells or success set");

endmodule

>>> bench/core_reservation_table_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for core_reservation_table: queue-fed request driver,
// response monitor with a cell-table predictor, and config writes between phases.
// Depends on crt_pkg, crt_ifc and the RTL top level.
module core_reservation_table_tb;

	localparam int NUM_CORES = crt_pkg::NUM_CORES_DEF;
	// worst claim: a full scan plus a rollback pass, with margin
	localparam int SETTLE_CYCLES = 2 * NUM_CORES + 3 + NUM_CORES + 1 + 16;
	localparam longint TIMEOUT_NS = 64'd15_000_000;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int NUM_PHASES = 10;

	typedef struct packed {
		crt_pkg::mode_t              mode;
		logic [crt_pkg::COUNT_W-1:0] request_count;
		logic [crt_pkg::INDEX_W-1:0] core_index;
	} core_request_t;

	typedef struct packed {
		logic [crt_pkg::MASK_W-1:0]  granted_mask;
		logic [crt_pkg::COUNT_W-1:0] found_count;
		logic                        success;
		logic [1:0]                  prior_state;
		logic                        index_error;
	} grant_result_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_STALLS
	} ready_pattern_t;

	logic clk;
	logic arst_n;

	crt_req_if req_ch ();
	crt_rsp_if rsp_ch ();
	crt_cfg_if cfg_ch ();

	core_reservation_table #(
		.NUM_CORES(NUM_CORES)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow of the cell table and the active_cores register
	crt_pkg::cell_t              cell_shadow [NUM_CORES];
	logic [crt_pkg::COUNT_W-1:0] active_cores_shadow;

	core_request_t  pending_requests [$];
	grant_result_t  expected_grants [$];
	int unsigned    req_queued;
	int unsigned    req_presented;
	int unsigned    req_accepted;
	int unsigned    fail_count;

	int unsigned    burst_left;
	int unsigned    gap_left;
	core_request_t  next_req;

	ready_pattern_t ready_pattern;
	int unsigned    pattern_timer;
	int unsigned    stall_left;

	int unsigned    phase_cfg [NUM_PHASES];

	function automatic int unsigned scan_limit_of(input logic [crt_pkg::COUNT_W-1:0] ac);
		return (ac > NUM_CORES) ? NUM_CORES : int'(ac);
	endfunction

	// Applies one request to the shadow table and returns the response it causes
	function automatic grant_result_t apply_request(input core_request_t rq);
		grant_result_t  r;
		int unsigned    lim;
		int unsigned    found;
		crt_pkg::cell_t prior;
		r = '0;
		found = 0;
		lim = scan_limit_of(active_cores_shadow);
		if (rq.mode == crt_pkg::MODE_CLAIM_MANY) begin
			for (int c = 0; c < lim && found < rq.request_count; c++) begin
				if (cell_shadow[c] == crt_pkg::CELL_VACANT) begin
					cell_shadow[c] = crt_pkg::CELL_OPP;
					r.granted_mask[c] = 1'b1;
					found++;
				end
			end
			if (found < rq.request_count) begin
				// all or nothing: undo this scan's claims
				for (int c = 0; c < lim; c++) begin
					if (r.granted_mask[c])
						cell_shadow[c] = crt_pkg::CELL_VACANT;
				end
				r.granted_mask = '0;
			end else begin
				r.success = 1'b1;
			end
			r.found_count = crt_pkg::COUNT_W'(found);
		end else if (rq.core_index >= lim) begin
			r.index_error = 1'b1;
		end else begin
			prior = cell_shadow[rq.core_index];
			r.prior_state = prior;
			case (rq.mode)
				crt_pkg::MODE_OWNER_CLAIM: begin
					if (prior != crt_pkg::CELL_OPP) begin
						r.success = 1'b1;
						if (prior == crt_pkg::CELL_VACANT)
							cell_shadow[rq.core_index] = crt_pkg::CELL_OWNER;
					end
				end
				crt_pkg::MODE_OPP_RELEASE: begin
					if (prior == crt_pkg::CELL_OPP)
						cell_shadow[rq.core_index] = crt_pkg::CELL_VACANT;
				end
				default: begin
					if (prior == crt_pkg::CELL_OWNER)
						cell_shadow[rq.core_index] = crt_pkg::CELL_VACANT;
				end
			endcase
		end
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 3);
		else if (r < 95)
			return $urandom_range(4, 40);
		else
			return $urandom_range(100, 250);
	endfunction

	task automatic push_req(input crt_pkg::mode_t m, input int unsigned cnt,
		input int unsigned idx);
		core_request_t rq;
		rq.mode = m;
		rq.request_count = crt_pkg::COUNT_W'(cnt);
		rq.core_index = crt_pkg::INDEX_W'(idx);
		pending_requests.push_back(rq);
		req_queued++;
	endtask

	// Mostly plausible traffic for the current limit, with sweeps and junk mixed in
	task automatic add_random_requests(input int unsigned lim, input int unsigned n);
		int unsigned added;
		int unsigned kind;
		int unsigned cnt;
		int unsigned idx;
		int unsigned r;
		added = 0;
		while (added < n) begin
			kind = $urandom_range(0, 99);
			if (lim > 0 && $urandom_range(0, 99) < 85)
				idx = $urandom_range(0, lim - 1);
			else
				idx = $urandom_range(0, NUM_CORES - 1);
			if (kind < 6 && lim > 0) begin
				// release sweep so claims can succeed again
				for (int i = 0; i < lim; i++)
					push_req(crt_pkg::MODE_OPP_RELEASE, $urandom_range(0, 127), i);
				added += lim;
			end else if (kind < 35) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					cnt = $urandom_range(0, 8);
				else if (r < 90)
					cnt = $urandom_range(0, lim + 2);
				else
					cnt = $urandom_range(0, 127);
				push_req(crt_pkg::MODE_CLAIM_MANY, cnt, $urandom_range(0, NUM_CORES - 1));
				added++;
			end else if (kind < 55) begin
				push_req(crt_pkg::MODE_OWNER_CLAIM, $urandom_range(0, 127), idx);
				added++;
			end else if (kind < 78) begin
				push_req(crt_pkg::MODE_OPP_RELEASE, $urandom_range(0, 127), idx);
				added++;
			end else begin
				push_req(crt_pkg::MODE_OWNER_RELEASE, $urandom_range(0, 127), idx);
				added++;
			end
		end
	endtask

	// Sender holds off until every response is back and the block has settled
	task automatic drain();
		do
			@(posedge clk);
		while (req_accepted != req_queued || expected_grants.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_active_cores(input int unsigned v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.active_cores <= crt_pkg::COUNT_W'(v);
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		active_cores_shadow = crt_pkg::COUNT_W'(v);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	// Request driver: bursts with random gaps, one request per handshake
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_accepted == req_presented) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_requests.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else begin
				next_req = pending_requests.pop_front();
				req_ch.mode <= next_req.mode;
				req_ch.request_count <= next_req.request_count;
				req_ch.core_index <= next_req.core_index;
				req_ch.valid <= 1'b1;
				req_presented <= req_presented + 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= pick_gap();
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Response ready: pattern is redrawn whenever its random timer runs out
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (pattern_timer == 0) begin
				ready_pattern <= ready_pattern_t'($urandom_range(0, 2));
				pattern_timer <= $urandom_range(50, 400);
			end else begin
				pattern_timer <= pattern_timer - 1;
			end
			case (ready_pattern)
				RDY_ALWAYS: rsp_ch.ready <= 1'b1;
				RDY_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: begin
					if (stall_left > 0) begin
						rsp_ch.ready <= 1'b0;
						stall_left <= stall_left - 1;
					end else begin
						rsp_ch.ready <= 1'b1;
						if ($urandom_range(0, 9) == 0)
							stall_left <= $urandom_range(1, 60);
					end
				end
			endcase
		end
	end

	// Monitor: check responses against the oldest prediction, then predict new requests
	always @(posedge clk) begin
		grant_result_t exp_r;
		core_request_t seen;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_grants.size() == 0) begin
					$error("response with no request outstanding");
					fail_count++;
				end else begin
					exp_r = expected_grants.pop_front();
					if (rsp_ch.granted_mask !== exp_r.granted_mask) begin
						$error("granted_mask: expected %h, actual %h",
							exp_r.granted_mask, rsp_ch.granted_mask);
						fail_count++;
					end
					if (rsp_ch.found_count !== exp_r.found_count) begin
						$error("found_count: expected %0d, actual %0d",
							exp_r.found_count, rsp_ch.found_count);
						fail_count++;
					end
					if (rsp_ch.success !== exp_r.success) begin
						$error("success: expected %0d, actual %0d",
							exp_r.success, rsp_ch.success);
						fail_count++;
					end
					if (rsp_ch.prior_state !== exp_r.prior_state) begin
						$error("prior_state: expected %0d, actual %0d",
							exp_r.prior_state, rsp_ch.prior_state);
						fail_count++;
					end
					if (rsp_ch.index_error !== exp_r.index_error) begin
						$error("index_error: expected %0d, actual %0d",
							exp_r.index_error, rsp_ch.index_error);
						fail_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.mode = crt_pkg::mode_t'(req_ch.mode);
				seen.request_count = req_ch.request_count;
				seen.core_index = req_ch.core_index;
				expected_grants.push_back(apply_request(seen));
				req_accepted <= req_accepted + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = '0;
		req_ch.request_count = '0;
		req_ch.core_index = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.active_cores = '0;
		for (int i = 0; i < NUM_CORES; i++)
			cell_shadow[i] = crt_pkg::CELL_VACANT;
		active_cores_shadow = crt_pkg::ACTIVE_CORES_RST;
		req_queued = 0;
		req_presented = 0;
		req_accepted = 0;
		fail_count = 0;
		burst_left = 1;
		gap_left = 0;
		ready_pattern = RDY_ALWAYS;
		pattern_timer = 0;
		stall_left = 0;
		phase_cfg = '{64, 1, 127, 2, 17, 65, 33, 48, 9, 64};
		phase_cfg[4] = $urandom_range(3, 63);
		phase_cfg[8] = $urandom_range(3, 63);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, at the reset value of active_cores
		push_req(crt_pkg::MODE_CLAIM_MANY, 0, 0);        // zero request
		push_req(crt_pkg::MODE_CLAIM_MANY, 5, 63);
		push_req(crt_pkg::MODE_OWNER_CLAIM, 0, 2);       // refused, opportunist holds it
		push_req(crt_pkg::MODE_OWNER_CLAIM, 127, 10);
		push_req(crt_pkg::MODE_OWNER_CLAIM, 0, 10);      // owner on owner cell
		push_req(crt_pkg::MODE_OPP_RELEASE, 0, 10);      // wrong holder, unchanged
		push_req(crt_pkg::MODE_OWNER_RELEASE, 0, 2);
		push_req(crt_pkg::MODE_OWNER_RELEASE, 0, 10);
		push_req(crt_pkg::MODE_OPP_RELEASE, 0, 3);
		push_req(crt_pkg::MODE_CLAIM_MANY, 64, 0);       // beyond limit, rollback
		push_req(crt_pkg::MODE_CLAIM_MANY, 127, 0);
		push_req(crt_pkg::MODE_OWNER_CLAIM, 0, 47);
		push_req(crt_pkg::MODE_OWNER_CLAIM, 0, 48);      // out of range
		push_req(crt_pkg::MODE_OPP_RELEASE, 0, 63);
		push_req(crt_pkg::MODE_CLAIM_MANY, 43, 0);       // takes every free cell
		push_req(crt_pkg::MODE_CLAIM_MANY, 1, 0);
		push_req(crt_pkg::MODE_OPP_RELEASE, 0, 0);
		push_req(crt_pkg::MODE_OWNER_RELEASE, 0, 47);
		push_req(crt_pkg::MODE_CLAIM_MANY, 2, 0);
		push_req(crt_pkg::MODE_OWNER_CLAIM, 0, 32);
		drain();

		write_active_cores(0);                  // nothing in range
		push_req(crt_pkg::MODE_CLAIM_MANY, 0, 0);
		push_req(crt_pkg::MODE_CLAIM_MANY, 1, 0);
		push_req(crt_pkg::MODE_OWNER_CLAIM, 0, 0);
		push_req(crt_pkg::MODE_OWNER_RELEASE, 0, 0);
		drain();

		write_active_cores(127);                // clipped to NUM_CORES
		push_req(crt_pkg::MODE_OWNER_CLAIM, 0, 63);
		push_req(crt_pkg::MODE_CLAIM_MANY, 127, 0);
		push_req(crt_pkg::MODE_CLAIM_MANY, 16, 0);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_active_cores(phase_cfg[p]);
			add_random_requests(scan_limit_of(crt_pkg::COUNT_W'(phase_cfg[p])),
				ITEMS_PER_PHASE);
			drain();
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/crt_pkg.sv
rtl/crt_ifc.sv
rtl/crt_cell_mem.sv
rtl/crt_ctrl.sv
rtl/core_reservation_table.sv
bench/core_reservation_table_tb.sv
